### src/slrl_pkg.sv
// Shared types and constants of the segment record loader.
`default_nettype none
package slrl_pkg;

	localparam logic [7:0] MAGIC0_BYTE     = 8'h89;
	localparam logic [7:0] MAGIC1_BYTE     = 8'h14;
	localparam logic [7:0] HDR_END         = 8'h00;
	localparam logic [7:0] HDR_ENTRY       = 8'h80;
	localparam logic [7:0] HDR_INFO        = 8'h81;
	localparam logic [7:0] GRAN_ONE        = 8'h01;
	localparam logic [7:0] RELOC_CPU_RESET = 8'h51;

	localparam int unsigned PADDR_W = 3;
	localparam logic CFG_IDX_RELOC_CPU = 1'b0;

	typedef enum logic [3:0] {
		PH_MAGIC0 = 4'd0,
		PH_MAGIC1 = 4'd1,
		PH_HEADER = 4'd2,
		PH_ENTRY  = 4'd3,
		PH_INFO   = 4'd4,
		PH_START  = 4'd5,
		PH_LENGTH = 4'd6,
		PH_DATA   = 4'd7,
		PH_HALT   = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		K_WRITE  = 3'd0,
		K_DONE   = 3'd1,
		K_MAGIC  = 3'd2,
		K_HEADER = 3'd3,
		K_GRAN   = 3'd4,
		K_ZERO   = 3'd5,
		K_NEG    = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] write_address;
		logic [7:0]  write_data;
		logic [31:0] relocated_total;
	} result_t;

endpackage
`default_nettype wire

### src/slrl_cfg.sv
// APB-style configuration register bank.
`default_nettype none
module slrl_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [slrl_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output logic      [7:0]                    relocated_cpu_code
);

	logic [7:0] reloc_cpu_q;
	logic       wr_en;
	logic       sel_reloc;

	assign pready    = 1'b1;
	assign sel_reloc = (paddr[2] == slrl_pkg::CFG_IDX_RELOC_CPU);
	assign wr_en     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reloc_cpu_q <= slrl_pkg::RELOC_CPU_RESET;
		end else if (wr_en && sel_reloc) begin
			reloc_cpu_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_reloc) begin
			prdata = {24'd0, reloc_cpu_q};
		end
	end

	assign relocated_cpu_code = reloc_cpu_q;

endmodule
`default_nettype wire

### src/slrl_parse.sv
// Record parser: parse state registers and the per-word next-state logic.
`default_nettype none
module slrl_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        stream_byte,
	input  wire logic              file_start,
	input  wire logic [7:0]        relocated_cpu_code,
	output logic                   res_valid,
	output slrl_pkg::result_t      res
);

	slrl_pkg::phase_t phase_q, phase_d, eff_phase;
	logic [1:0]  fbc_q, fbc_d, eff_fbc;
	logic [7:0]  cpu_q, cpu_d, eff_cpu;
	logic [31:0] seg_start_q, seg_start_d, eff_seg_start;
	logic [15:0] seg_len_q, seg_len_d, eff_seg_len;
	logic [15:0] remain_q, remain_d, eff_remain;
	logic [31:0] wptr_q, wptr_d, eff_wptr;
	logic [31:0] prev_start_q, prev_start_d, eff_prev_start;
	logic [15:0] prev_len_q, prev_len_d, eff_prev_len;
	logic [31:0] total_q, total_d, eff_total;

	logic [15:0] full_len;
	logic [32:0] total_sum;
	logic [31:0] packed_start;
	logic [31:0] byte_lane;
	logic        relocate;

	// A file start restarts from the cleared state before the word is parsed.
	always_comb begin
		if (file_start) begin
			eff_phase      = slrl_pkg::PH_MAGIC0;
			eff_fbc        = '0;
			eff_cpu        = '0;
			eff_seg_start  = '0;
			eff_seg_len    = '0;
			eff_remain     = '0;
			eff_wptr       = '0;
			eff_prev_start = '0;
			eff_prev_len   = '0;
			eff_total      = '0;
		end else begin
			eff_phase      = phase_q;
			eff_fbc        = fbc_q;
			eff_cpu        = cpu_q;
			eff_seg_start  = seg_start_q;
			eff_seg_len    = seg_len_q;
			eff_remain     = remain_q;
			eff_wptr       = wptr_q;
			eff_prev_start = prev_start_q;
			eff_prev_len   = prev_len_q;
			eff_total      = total_q;
		end
	end

	assign full_len     = {stream_byte, eff_seg_len[7:0]};
	assign total_sum    = {1'b0, eff_total} + {17'd0, full_len};
	assign packed_start = eff_prev_start + {16'd0, eff_prev_len};
	assign byte_lane    = {24'd0, stream_byte} << {eff_fbc, 3'b000};
	assign relocate     = (eff_cpu == relocated_cpu_code);

	always_comb begin
		phase_d      = eff_phase;
		fbc_d        = eff_fbc;
		cpu_d        = eff_cpu;
		seg_start_d  = eff_seg_start;
		seg_len_d    = eff_seg_len;
		remain_d     = eff_remain;
		wptr_d       = eff_wptr;
		prev_start_d = eff_prev_start;
		prev_len_d   = eff_prev_len;
		total_d      = eff_total;

		res_valid           = 1'b0;
		res.kind            = slrl_pkg::K_WRITE;
		res.write_address   = '0;
		res.write_data      = '0;
		res.relocated_total = eff_total;

		unique case (eff_phase)
			slrl_pkg::PH_MAGIC0: begin
				phase_d = slrl_pkg::PH_MAGIC1;
				if (stream_byte != slrl_pkg::MAGIC0_BYTE) begin
					res_valid = 1'b1;
					res.kind  = slrl_pkg::K_MAGIC;
				end
			end
			slrl_pkg::PH_MAGIC1: begin
				phase_d = slrl_pkg::PH_HEADER;
				if (stream_byte != slrl_pkg::MAGIC1_BYTE) begin
					res_valid = 1'b1;
					res.kind  = slrl_pkg::K_MAGIC;
				end
			end
			slrl_pkg::PH_HEADER: begin
				if (stream_byte == slrl_pkg::HDR_END) begin
					phase_d   = slrl_pkg::PH_HALT;
					res_valid = 1'b1;
					res.kind  = slrl_pkg::K_DONE;
				end else if (stream_byte == slrl_pkg::HDR_ENTRY) begin
					phase_d = slrl_pkg::PH_ENTRY;
					fbc_d   = '0;
				end else if (stream_byte == slrl_pkg::HDR_INFO) begin
					phase_d = slrl_pkg::PH_INFO;
					fbc_d   = '0;
				end else if (stream_byte > slrl_pkg::HDR_INFO) begin
					phase_d   = slrl_pkg::PH_HALT;
					res_valid = 1'b1;
					res.kind  = slrl_pkg::K_HEADER;
				end else begin
					// header byte is the cpu code itself
					cpu_d       = stream_byte;
					phase_d     = slrl_pkg::PH_START;
					fbc_d       = '0;
					seg_start_d = '0;
				end
			end
			slrl_pkg::PH_ENTRY: begin
				if (eff_fbc >= 2'd2) begin
					phase_d = slrl_pkg::PH_HEADER;
				end else begin
					fbc_d = eff_fbc + 2'd1;
				end
			end
			slrl_pkg::PH_INFO: begin
				if (eff_fbc == 2'd0) begin
					cpu_d = stream_byte;
					fbc_d = 2'd1;
				end else if (eff_fbc == 2'd1) begin
					fbc_d = 2'd2;
				end else if (stream_byte != slrl_pkg::GRAN_ONE) begin
					phase_d   = slrl_pkg::PH_HALT;
					res_valid = 1'b1;
					res.kind  = slrl_pkg::K_GRAN;
				end else begin
					phase_d     = slrl_pkg::PH_START;
					fbc_d       = '0;
					seg_start_d = '0;
				end
			end
			slrl_pkg::PH_START: begin
				seg_start_d = eff_seg_start | byte_lane;
				if (eff_fbc == 2'd3) begin
					phase_d   = slrl_pkg::PH_LENGTH;
					fbc_d     = '0;
					seg_len_d = '0;
				end else begin
					fbc_d = eff_fbc + 2'd1;
				end
			end
			slrl_pkg::PH_LENGTH: begin
				if (eff_fbc == 2'd0) begin
					seg_len_d = {8'd0, stream_byte};
					fbc_d     = 2'd1;
				end else begin
					seg_len_d = full_len;
					fbc_d     = '0;
					if (full_len == 16'd0) begin
						phase_d   = slrl_pkg::PH_HALT;
						res_valid = 1'b1;
						res.kind  = slrl_pkg::K_ZERO;
					end else if (eff_seg_start[31]) begin
						phase_d   = slrl_pkg::PH_HALT;
						res_valid = 1'b1;
						res.kind  = slrl_pkg::K_NEG;
					end else begin
						// pack relocated segments right after the previous one
						if (relocate) begin
							seg_start_d  = packed_start;
							prev_start_d = packed_start;
							wptr_d       = packed_start;
							total_d      = total_sum[32] ? '1 : total_sum[31:0];
						end else begin
							prev_start_d = eff_seg_start;
							wptr_d       = eff_seg_start;
						end
						prev_len_d = full_len;
						remain_d   = full_len;
						phase_d    = slrl_pkg::PH_DATA;
					end
				end
			end
			slrl_pkg::PH_DATA: begin
				res_valid         = 1'b1;
				res.kind          = slrl_pkg::K_WRITE;
				res.write_address = eff_wptr;
				res.write_data    = stream_byte;
				wptr_d            = eff_wptr + 32'd1;
				remain_d          = eff_remain - 16'd1;
				if (eff_remain == 16'd1) begin
					phase_d = slrl_pkg::PH_HEADER;
				end
			end
			slrl_pkg::PH_HALT: begin
				// drop everything until the next file start
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= slrl_pkg::PH_MAGIC0;
			fbc_q        <= '0;
			cpu_q        <= '0;
			seg_start_q  <= '0;
			seg_len_q    <= '0;
			remain_q     <= '0;
			wptr_q       <= '0;
			prev_start_q <= '0;
			prev_len_q   <= '0;
			total_q      <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			fbc_q        <= fbc_d;
			cpu_q        <= cpu_d;
			seg_start_q  <= seg_start_d;
			seg_len_q    <= seg_len_d;
			remain_q     <= remain_d;
			wptr_q       <= wptr_d;
			prev_start_q <= prev_start_d;
			prev_len_q   <= prev_len_d;
			total_q      <= total_d;
		end
	end

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == slrl_pkg::PH_DATA) |-> (remain_q != 16'd0))
		else $error("data phase with no bytes remaining");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == slrl_pkg::PH_HALT && !file_start) |-> !res_valid)
		else $error("result produced while halted");

endmodule
`default_nettype wire

### src/slrl_out_buf.sv
// Result register with a skid stage, so a stalled receiver does not block intake.
`default_nettype none
module slrl_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire slrl_pkg::result_t push_data,
	output logic                   space,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output slrl_pkg::result_t      out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	slrl_pkg::result_t out_q;
	slrl_pkg::result_t skid_q;
	logic              pop;
	logic              load_out;

	assign pop      = out_valid_q && out_ready;
	assign load_out = !out_valid_q || pop;
	assign space    = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end
		if (!load_out && push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with empty output register");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !pop) |=> (skid_valid_q && $stable(skid_q)))
		else $error("skid word lost or overwritten");

endmodule
`default_nettype wire

### src/segment_record_loader_unit.sv
// Top level of the segment record loader.
//
// Input channel: one object-file byte per word (stream_byte, file_start)
// under byte_valid / byte_ready. A word with file_start set clears the parse
// state and counts as the first magic byte.
// Output channel: kind, write_address, write_data, relocated_total under
// result_valid / result_ready; a word yields zero or one result.
// Configuration: APB-style port, relocated_cpu_code at byte address 0.
// Each result is registered in the result register or the skid word.
// Throughput: one byte per cycle while byte_ready is high; the whole parse
// step sits between the parse state registers and the result register.
// Stall: a result register plus one skid word absorb a stalled receiver;
// byte_ready drops only when both hold words, and rises again once the
// receiver takes one.
// Reset: relocated_cpu_code returns to 0x51, the parser waits for the first
// magic byte, and both result words are emptied.
`default_nettype none
module segment_record_loader_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          byte_valid,
	output logic                               byte_ready,
	input  wire logic [7:0]                    stream_byte,
	input  wire logic                          file_start,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic      [2:0]                    kind,
	output logic      [31:0]                   write_address,
	output logic      [7:0]                    write_data,
	output logic      [31:0]                   relocated_total,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [slrl_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	logic              accept;
	logic              res_valid;
	logic              space;
	logic [7:0]        reloc_cpu;
	slrl_pkg::result_t res;
	slrl_pkg::result_t out_data;

	assign byte_ready = space;
	assign accept     = byte_valid && byte_ready;

	slrl_cfg u_cfg (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.relocated_cpu_code (reloc_cpu)
	);

	slrl_parse u_parse (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.stream_byte        (stream_byte),
		.file_start         (file_start),
		.relocated_cpu_code (reloc_cpu),
		.res_valid          (res_valid),
		.res                (res)
	);

	slrl_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (out_data)
	);

	assign kind            = out_data.kind;
	assign write_address   = out_data.write_address;
	assign write_data      = out_data.write_data;
	assign relocated_total = out_data.relocated_total;

endmodule
`default_nettype wire
